FILE: rtl/maf_pkg.sv
// Shared types and constants for the moving average filter.
// Used by every module of the block but maf_ram; no dependencies.
`default_nettype none

package maf_pkg;

  // Default build values
  localparam int MAX_WINDOW_DEF  = 1024;
  localparam int SAMPLE_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  // Fixed register widths
  localparam int GAIN_BITS  = 16;
  localparam int MODE_W     = 2;
  localparam int WLEN_W     = 11;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_AVG_MODE      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXP_GAIN      = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_LENGTH    = 4'd3;

  // Averaging modes; the unused code behaves as simple
  localparam logic [MODE_W-1:0] MODE_SIMPLE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_EXP      = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SMOOTHED = 2'd2;

  // Register reset values
  localparam logic [MODE_W-1:0]    AVG_MODE_RST      = MODE_SIMPLE;
  localparam logic [WLEN_W-1:0]    WINDOW_LENGTH_RST = 11'd2;
  localparam logic [GAIN_BITS-1:0] EXP_GAIN_RST      = 16'd43691;
  localparam logic [GAIN_BITS-1:0] INV_LENGTH_RST    = 16'd32768;

  // Per-stage control flags that travel with a transaction
  typedef struct packed {
    logic valid;
    logic nonzero;
    logic full_before;
    logic ready;
  } stage_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/maf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Read-first on a same-address collision; no dependencies.
`default_nettype none

module maf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/maf_front.sv
// Front stage: ring slot pointer, sample count and ring addressing.
// Depends on maf_pkg; drives the ring RAM instanced at the top level.
`default_nettype none

module maf_front
  import maf_pkg::*;
#(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              accept_i,
  input  wire logic                              advance_i,
  input  wire logic                              clear_i,
  input  wire logic [$clog2(MAX_WINDOW+1)-1:0]   period_i,
  input  wire logic signed [SAMPLE_BITS-1:0]     sample_i,
  output logic                                   ring_we_o,
  output logic                                   ring_re_o,
  output logic      [$clog2(MAX_WINDOW)-1:0]     ring_addr_o,
  output stage_ctrl_t                            s1_ctrl_o,
  output logic signed [SAMPLE_BITS-1:0]          s1_sample_o
);

  localparam int ADDR_W = $clog2(MAX_WINDOW);
  localparam int CNT_W  = $clog2(MAX_WINDOW+1);

  logic [ADDR_W-1:0] slot_q, slot_d, slot_cur;
  logic [CNT_W-1:0]  seen_q, seen_d;
  logic [CNT_W-1:0]  slot_inc;
  logic              full, nonzero;
  stage_ctrl_t       s1_ctrl_q;
  logic signed [SAMPLE_BITS-1:0] s1_sample_q;

  always_comb begin
    slot_cur = (CNT_W'(slot_q) >= period_i) ? '0 : slot_q;
    full     = (seen_q >= period_i);
    nonzero  = (sample_i != '0);
    seen_d   = full ? seen_q : seen_q + CNT_W'(1);
    slot_inc = CNT_W'(slot_cur) + CNT_W'(1);
    slot_d   = (slot_inc >= period_i) ? '0 : slot_inc[ADDR_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      seen_q <= '0;
    end else if (clear_i) begin
      slot_q <= '0;
      seen_q <= '0;
    end else if (accept_i && nonzero) begin
      slot_q <= slot_d;
      seen_q <= seen_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_ctrl_q <= '0;
    end else if (advance_i) begin
      s1_ctrl_q.valid       <= accept_i;
      s1_ctrl_q.nonzero     <= nonzero;
      s1_ctrl_q.full_before <= full;
      s1_ctrl_q.ready       <= nonzero && (seen_d >= period_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      s1_sample_q <= sample_i;
    end
  end

  // The old sample comes out of the read port while the new one is written
  assign ring_we_o   = accept_i && nonzero;
  assign ring_re_o   = accept_i;
  assign ring_addr_o = slot_cur;
  assign s1_ctrl_o   = s1_ctrl_q;
  assign s1_sample_o = s1_sample_q;

endmodule

`default_nettype wire

FILE: rtl/maf_accum.sv
// Running window sum and windowed mean (sum times 1/N, rescaled, saturated).
// Depends on maf_pkg; fed by maf_front and the ring RAM read port.
`default_nettype none

module maf_accum
  import maf_pkg::*;
#(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   advance_i,
  input  wire logic                                   clear_i,
  input  wire logic [GAIN_BITS-1:0]                   inv_length_i,
  input  wire stage_ctrl_t                            s1_ctrl_i,
  input  wire logic signed [SAMPLE_BITS-1:0]          s1_sample_i,
  input  wire logic signed [SAMPLE_BITS-1:0]          ring_old_i,
  output stage_ctrl_t                                 s3_ctrl_o,
  output logic signed [SAMPLE_BITS-1:0]               s3_sample_o,
  output logic signed [SAMPLE_BITS+FRAC_BITS-1:0]     s3_mean_o
);

  localparam int SUM_W   = SAMPLE_BITS + $clog2(MAX_WINDOW) + 1;
  localparam int AVG_W   = SAMPLE_BITS + FRAC_BITS;
  localparam int FRAC_UP = (FRAC_BITS >= GAIN_BITS) ? FRAC_BITS - GAIN_BITS : 0;
  localparam int FRAC_DN = (FRAC_BITS < GAIN_BITS) ? GAIN_BITS - FRAC_BITS : 0;
  localparam int MP_W    = SUM_W + GAIN_BITS + 1;
  localparam int MW_W    = MP_W + FRAC_UP;

  localparam logic signed [AVG_W-1:0] AVG_MAX = {1'b0, {(AVG_W-1){1'b1}}};
  localparam logic signed [AVG_W-1:0] AVG_MIN = {1'b1, {(AVG_W-1){1'b0}}};

  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic signed [SUM_W-1:0] drop;
  logic signed [MP_W-1:0]  prod;
  logic signed [MW_W-1:0]  scaled;
  logic [MW_W-AVG_W:0]     top_bits;
  logic signed [AVG_W-1:0] mean_d, mean_q;
  stage_ctrl_t             s2_ctrl_q, s3_ctrl_q;
  logic signed [SAMPLE_BITS-1:0] s2_sample_q, s3_sample_q;

  // Stage 2: slide the window sum
  always_comb begin
    drop  = s1_ctrl_i.full_before ? SUM_W'(ring_old_i) : '0;
    sum_d = sum_q - drop + SUM_W'(s1_sample_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (clear_i) begin
      sum_q <= '0;
    end else if (advance_i && s1_ctrl_i.valid && s1_ctrl_i.nonzero) begin
      sum_q <= sum_d;
    end
  end

  // Stage 3: mean from the sum left by the transaction now in stage 2
  always_comb begin
    prod     = sum_q * $signed({1'b0, inv_length_i});
    scaled   = (MW_W'(prod) <<< FRAC_UP) >>> FRAC_DN;
    top_bits = scaled[MW_W-1:AVG_W-1];
    if (&top_bits || ~|top_bits) begin
      mean_d = scaled[AVG_W-1:0];
    end else begin
      mean_d = scaled[MW_W-1] ? AVG_MIN : AVG_MAX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_ctrl_q <= '0;
      s3_ctrl_q <= '0;
    end else if (advance_i) begin
      s2_ctrl_q <= s1_ctrl_i;
      s3_ctrl_q <= s2_ctrl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      s2_sample_q <= s1_sample_i;
      s3_sample_q <= s2_sample_q;
      mean_q      <= mean_d;
    end
  end

  assign s3_ctrl_o   = s3_ctrl_q;
  assign s3_sample_o = s3_sample_q;
  assign s3_mean_o   = mean_q;

endmodule

`default_nettype wire

FILE: rtl/maf_smooth.sv
// Exponential / smoothed average update and the output register.
// Depends on maf_pkg; fed by maf_accum.
`default_nettype none

module maf_smooth
  import maf_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 advance_i,
  input  wire logic                                 clear_i,
  input  wire logic [MODE_W-1:0]                    avg_mode_i,
  input  wire logic [GAIN_BITS-1:0]                 exp_gain_i,
  input  wire logic [GAIN_BITS-1:0]                 inv_length_i,
  input  wire stage_ctrl_t                          s3_ctrl_i,
  input  wire logic signed [SAMPLE_BITS-1:0]        s3_sample_i,
  input  wire logic signed [SAMPLE_BITS+FRAC_BITS-1:0] s3_mean_i,
  output logic                                      out_valid_o,
  output logic                                      ready_res_o,
  output logic signed [SAMPLE_BITS-1:0]             source_sample_o,
  output logic signed [SAMPLE_BITS+FRAC_BITS-1:0]   average_value_o
);

  localparam int AVG_W = SAMPLE_BITS + FRAC_BITS;
  localparam int DF_W  = AVG_W + 1;
  localparam int PR_W  = DF_W + GAIN_BITS + 1;
  localparam int TT_W  = PR_W + 1;

  localparam logic signed [AVG_W-1:0] AVG_MAX = {1'b0, {(AVG_W-1){1'b1}}};
  localparam logic signed [AVG_W-1:0] AVG_MIN = {1'b1, {(AVG_W-1){1'b0}}};

  logic signed [AVG_W-1:0] avg_q, avg_d, avg_out_q;
  logic signed [AVG_W-1:0] xq;
  logic signed [DF_W-1:0]  diff;
  logic [GAIN_BITS-1:0]    gain;
  logic signed [PR_W-1:0]  prod, step;
  logic signed [TT_W-1:0]  total;
  logic [TT_W-AVG_W:0]     top_bits;
  logic signed [AVG_W-1:0] blend;
  logic                    recursive, update;
  logic                    out_valid_q, ready_q;
  logic signed [SAMPLE_BITS-1:0] source_q;

  always_comb begin
    recursive = (avg_mode_i == MODE_EXP) || (avg_mode_i == MODE_SMOOTHED);
    gain      = (avg_mode_i == MODE_EXP) ? exp_gain_i : inv_length_i;
    xq        = AVG_W'(s3_sample_i) <<< FRAC_BITS;
    diff      = DF_W'(xq) - DF_W'(avg_q);
    prod      = diff * $signed({1'b0, gain});
    // floor of the Q0.16 product
    step      = prod >>> GAIN_BITS;
    total     = TT_W'(avg_q) + TT_W'(step);
    top_bits  = total[TT_W-1:AVG_W-1];
    if (&top_bits || ~|top_bits) begin
      blend = total[AVG_W-1:0];
    end else begin
      blend = total[TT_W-1] ? AVG_MIN : AVG_MAX;
    end
    // Seed with the plain mean on the first full window
    avg_d  = (recursive && s3_ctrl_i.full_before) ? blend : s3_mean_i;
    update = s3_ctrl_i.valid && s3_ctrl_i.nonzero && s3_ctrl_i.ready;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_q <= '0;
    end else if (clear_i) begin
      avg_q <= '0;
    end else if (advance_i && update) begin
      avg_q <= avg_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      ready_q     <= 1'b0;
    end else if (advance_i) begin
      out_valid_q <= s3_ctrl_i.valid;
      ready_q     <= update;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      source_q  <= s3_sample_i;
      avg_out_q <= update ? avg_d : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign ready_res_o     = ready_q;
  assign source_sample_o = source_q;
  assign average_value_o = avg_out_q;

endmodule

`default_nettype wire

FILE: rtl/moving_average_filter.sv
// Moving average filter, top level: configuration registers, ring RAM, pipeline.
// Depends on maf_pkg, maf_ram, maf_front, maf_accum and maf_smooth.
//
// Takes one signed price sample per cycle while in_stall is low and returns one
// transaction per sample, in order, via s1, s2, s3 and the output register. Zero
// samples pass through with ready_res low and leave the state alone. The last N
// samples sit in a ring RAM: each transaction reads the slot it overwrites in the
// same cycle, so the ring costs one read and at most one write per sample.
// The exponential and smoothed update is a loop of one multiply and one add per
// cycle, which sets the sustained rate of one sample per clock. The pipeline
// holds as a whole while the output register is stalled; there is no clearing
// pass after reset. Write avg_mode or window_length only while idle: either
// write restarts the window. Gain writes take effect immediately.
`default_nettype none

module moving_average_filter
  import maf_pkg::*;
#(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic signed [SAMPLE_BITS-1:0]        price_sample_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic                                      ready_res_o,
  output logic signed [SAMPLE_BITS-1:0]             source_sample_o,
  output logic signed [SAMPLE_BITS+FRAC_BITS-1:0]   average_value_o,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]                 cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]                cfg_data_i
);

  localparam int ADDR_W = $clog2(MAX_WINDOW);
  localparam int CNT_W  = $clog2(MAX_WINDOW+1);
  localparam int CMP_W  = (CNT_W > WLEN_W) ? CNT_W : WLEN_W;

  logic [MODE_W-1:0]    avg_mode_q;
  logic [WLEN_W-1:0]    window_length_q;
  logic [GAIN_BITS-1:0] exp_gain_q;
  logic [GAIN_BITS-1:0] inv_length_q;

  logic                 clear, advance, accept;
  logic [CMP_W-1:0]     wl_ext, period_ext;
  logic [CNT_W-1:0]     period;

  logic                 ring_we, ring_re;
  logic [ADDR_W-1:0]    ring_addr;
  logic signed [SAMPLE_BITS-1:0] ring_old;
  stage_ctrl_t          s1_ctrl, s3_ctrl;
  logic signed [SAMPLE_BITS-1:0] s1_sample, s3_sample;
  logic signed [SAMPLE_BITS+FRAC_BITS-1:0] s3_mean;

  // Configuration
  assign cfg_ready_o = 1'b1;
  assign clear = cfg_valid_i &&
                 ((cfg_index_i == REG_AVG_MODE) || (cfg_index_i == REG_WINDOW_LENGTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_mode_q      <= AVG_MODE_RST;
      window_length_q <= WINDOW_LENGTH_RST;
      exp_gain_q      <= EXP_GAIN_RST;
      inv_length_q    <= INV_LENGTH_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_AVG_MODE:      avg_mode_q      <= cfg_data_i[MODE_W-1:0];
        REG_WINDOW_LENGTH: window_length_q <= cfg_data_i[WLEN_W-1:0];
        REG_EXP_GAIN:      exp_gain_q      <= cfg_data_i[GAIN_BITS-1:0];
        REG_INV_LENGTH:    inv_length_q    <= cfg_data_i[GAIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the period to 2..MAX_WINDOW
  always_comb begin
    wl_ext = CMP_W'(window_length_q);
    if (wl_ext < CMP_W'(2)) begin
      period_ext = CMP_W'(2);
    end else if (wl_ext > CMP_W'(MAX_WINDOW)) begin
      period_ext = CMP_W'(MAX_WINDOW);
    end else begin
      period_ext = wl_ext;
    end
    period = period_ext[CNT_W-1:0];
  end

  // Hold the whole pipeline while the output transaction is stalled
  assign advance    = !(out_valid_o && out_stall_i);
  assign in_stall_o = !advance;
  assign accept     = in_valid_i && advance;

  maf_front #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .advance_i   (advance),
    .clear_i     (clear),
    .period_i    (period),
    .sample_i    (price_sample_i),
    .ring_we_o   (ring_we),
    .ring_re_o   (ring_re),
    .ring_addr_o (ring_addr),
    .s1_ctrl_o   (s1_ctrl),
    .s1_sample_o (s1_sample)
  );

  maf_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_addr),
    .wdata_i (price_sample_i),
    .re_i    (ring_re),
    .raddr_i (ring_addr),
    .rdata_o (ring_old)
  );

  maf_accum #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .advance_i    (advance),
    .clear_i      (clear),
    .inv_length_i (inv_length_q),
    .s1_ctrl_i    (s1_ctrl),
    .s1_sample_i  (s1_sample),
    .ring_old_i   (ring_old),
    .s3_ctrl_o    (s3_ctrl),
    .s3_sample_o  (s3_sample),
    .s3_mean_o    (s3_mean)
  );

  maf_smooth #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_smooth (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .advance_i       (advance),
    .clear_i         (clear),
    .avg_mode_i      (avg_mode_q),
    .exp_gain_i      (exp_gain_q),
    .inv_length_i    (inv_length_q),
    .s3_ctrl_i       (s3_ctrl),
    .s3_sample_i     (s3_sample),
    .s3_mean_i       (s3_mean),
    .out_valid_o     (out_valid_o),
    .ready_res_o     (ready_res_o),
    .source_sample_o (source_sample_o),
    .average_value_o (average_value_o)
  );

endmodule

`default_nettype wire

FILE: tb/sv/moving_average_checker.sv
`timescale 1ns / 100ps
// Result checker for the moving average filter: predicts every output transaction.
// Watches the sample, result and configuration channels; depends on maf_pkg.

module moving_average_checker
  import maf_pkg::*;
#(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  input  logic                                 in_stall_i,
  input  logic [SAMPLE_BITS-1:0]               price_sample_i,
  input  logic                                 out_valid_i,
  input  logic                                 out_stall_i,
  input  logic                                 ready_res_i,
  input  logic [SAMPLE_BITS-1:0]               source_sample_i,
  input  logic [SAMPLE_BITS+FRAC_BITS-1:0]     average_value_i,
  input  logic                                 cfg_valid_i,
  input  logic                                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]                 cfg_index_i,
  input  logic [CFG_DATA_W-1:0]                cfg_data_i,
  output int                                   fail_count_o,
  output int                                   pending_o
);

  localparam int AVG_W     = SAMPLE_BITS + FRAC_BITS;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;
    logic [AVG_W-1:0]       average;
  } avg_result_t;

  logic [MODE_W-1:0]             mode_q;
  logic [WLEN_W-1:0]             wlen_q;
  logic [GAIN_BITS-1:0]          exp_gain_q;
  logic [GAIN_BITS-1:0]          inv_len_q;

  logic signed [SAMPLE_BITS-1:0] price_ring [MAX_WINDOW];
  int unsigned                   slot;
  int unsigned                   seen;
  wide_t                         run_sum;
  logic signed [AVG_W-1:0]       avg_q;

  avg_result_t                   expected_avg_q[$];
  int                            fails;

  function automatic logic signed [AVG_W-1:0] clamp_avg(input wide_t v);
    wide_t hi;
    wide_t lo;
    hi = (wide_t'(1) <<< (AVG_W - 1)) - wide_t'(1);
    lo = -hi - wide_t'(1);
    if (v > hi) return hi[AVG_W-1:0];
    if (v < lo) return lo[AVG_W-1:0];
    return v[AVG_W-1:0];
  endfunction

  // floor(v * g / 2^GAIN_BITS), gain unsigned
  function automatic wide_t scale_by_gain(input wide_t v, input logic [GAIN_BITS-1:0] g);
    wide_t prod;
    prod = v * wide_t'({1'b0, g});
    return prod >>> GAIN_BITS;
  endfunction

  function automatic int unsigned window_period(input logic [WLEN_W-1:0] w);
    if (w < 2) return 2;
    if (w > MAX_WINDOW) return MAX_WINDOW;
    return w;
  endfunction

  task automatic clear_window();
    slot    = 0;
    seen    = 0;
    run_sum = '0;
    avg_q   = '0;
  endtask

  task automatic predict_average(input logic signed [SAMPLE_BITS-1:0] x,
                                 output avg_result_t r);
    int unsigned          n;
    logic                 full_before;
    wide_t                mean;
    wide_t                xq;
    logic [GAIN_BITS-1:0] g;
    n         = window_period(wlen_q);
    r.ready   = 1'b0;
    r.sample  = x;
    r.average = '0;
    // zero means no sample: leave the window alone
    if (x == 0) return;

    if (slot >= n) slot = 0;
    full_before = (seen >= n);
    if (full_before) run_sum = run_sum - wide_t'(price_ring[slot]);
    else seen++;
    run_sum = run_sum + wide_t'(x);
    price_ring[slot] = x;
    slot = (slot + 1 >= n) ? 0 : slot + 1;
    if (seen < n) return;

    mean = run_sum * wide_t'({1'b0, inv_len_q});
    if (FRAC_BITS >= GAIN_BITS) mean = mean <<< (FRAC_BITS - GAIN_BITS);
    else mean = mean >>> (GAIN_BITS - FRAC_BITS);
    mean = clamp_avg(mean);

    xq = wide_t'(x) <<< FRAC_BITS;
    // seed the recursive modes with the mean, then follow the gain update
    if ((mode_q == MODE_EXP || mode_q == MODE_SMOOTHED) && full_before) begin
      g = (mode_q == MODE_EXP) ? exp_gain_q : inv_len_q;
      avg_q = clamp_avg(wide_t'(avg_q) + scale_by_gain(xq - wide_t'(avg_q), g));
    end else begin
      avg_q = mean[AVG_W-1:0];
    end
    r.ready   = 1'b1;
    r.average = avg_q;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch_channels
    avg_result_t want;
    avg_result_t got;
    if (!rst_ni) begin
      mode_q     = AVG_MODE_RST;
      wlen_q     = WINDOW_LENGTH_RST;
      exp_gain_q = EXP_GAIN_RST;
      inv_len_q  = INV_LENGTH_RST;
      clear_window();
      expected_avg_q.delete();
      fails        = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_AVG_MODE: begin
            mode_q = cfg_data_i[MODE_W-1:0];
            clear_window();
          end
          REG_WINDOW_LENGTH: begin
            wlen_q = cfg_data_i[WLEN_W-1:0];
            clear_window();
          end
          REG_EXP_GAIN: begin
            exp_gain_q = cfg_data_i[GAIN_BITS-1:0];
          end
          REG_INV_LENGTH: begin
            inv_len_q = cfg_data_i[GAIN_BITS-1:0];
          end
          default: begin
          end
        endcase
      end

      if (in_valid_i && !in_stall_i) begin
        predict_average(price_sample_i, want);
        expected_avg_q.push_back(want);
      end

      if (out_valid_i && !out_stall_i) begin
        got.ready   = ready_res_i;
        got.sample  = source_sample_i;
        got.average = average_value_i;
        if (expected_avg_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result: expected none, actual ready %b sample %0d avg %0d",
                   $time, got.ready, $signed(got.sample), $signed(got.average));
        end else begin
          want = expected_avg_q.pop_front();
          if (got !== want) begin
            fails++;
            if (got.ready !== want.ready)
              $display("%0t: ready_res expected %b actual %b",
                       $time, want.ready, got.ready);
            if (got.sample !== want.sample)
              $display("%0t: source_sample expected %0d actual %0d",
                       $time, $signed(want.sample), $signed(got.sample));
            if (got.average !== want.average)
              $display("%0t: average_value expected %0d actual %0d",
                       $time, $signed(want.average), $signed(got.average));
          end
        end
      end

      fail_count_o <= fails;
      pending_o    <= expected_avg_q.size();
    end
  end

endmodule

FILE: tb/sv/moving_average_filter_tb.sv
`timescale 1ns / 100ps
// Testbench top for the moving average filter: clock, reset, stimulus and verdict.
// Depends on maf_pkg, moving_average_filter and moving_average_checker.

module moving_average_filter_tb;
  import maf_pkg::*;

  localparam int SAMPLE_W       = SAMPLE_BITS_DEF;
  localparam int AVG_W          = SAMPLE_BITS_DEF + FRAC_BITS_DEF;
  localparam int PIPE_SETTLE    = 8;
  localparam int FINAL_SETTLE   = 16;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam logic [MODE_W-1:0]   MODE_UNUSED = 2'd3;
  localparam logic [SAMPLE_W-1:0] PRICE_MAX   = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic [SAMPLE_W-1:0] PRICE_MIN   = {1'b1, {(SAMPLE_W-1){1'b0}}};

  logic                  clk;
  logic                  rst_n         = 1'b0;
  logic                  in_valid      = 1'b0;
  logic                  in_stall;
  logic [SAMPLE_W-1:0]   price_sample  = '0;
  logic                  out_valid;
  logic                  out_stall     = 1'b0;
  logic                  ready_res;
  logic [SAMPLE_W-1:0]   source_sample;
  logic [AVG_W-1:0]      average_value;
  logic                  cfg_valid     = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index     = '0;
  logic [CFG_DATA_W-1:0] cfg_data      = '0;

  int fail_count;
  int pending;
  int snd_idle_pct  = 0;
  int rcv_stall_pct = 0;
  int idle_cycles   = 0;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  moving_average_filter uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .price_sample_i (price_sample),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .ready_res_o    (ready_res),
    .source_sample_o(source_sample),
    .average_value_o(average_value),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  moving_average_checker checker_inst (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .price_sample_i (price_sample),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .ready_res_i    (ready_res),
    .source_sample_i(source_sample),
    .average_value_i(average_value),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
  end

  // end the run when no channel moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_filter(input logic [CFG_DATA_W-1:0] mode_data,
                            input logic [CFG_DATA_W-1:0] wlen_data,
                            input logic [CFG_DATA_W-1:0] exp_gain,
                            input logic [CFG_DATA_W-1:0] inv_len);
    write_reg(REG_AVG_MODE, mode_data);
    write_reg(REG_WINDOW_LENGTH, wlen_data);
    write_reg(REG_EXP_GAIN, exp_gain);
    write_reg(REG_INV_LENGTH, inv_len);
  endtask

  task automatic send_sample(input logic [SAMPLE_W-1:0] x);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    price_sample <= x;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // hold the sender until every predicted result is out, then let the pipe settle
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_price();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) begin
      case ($urandom_range(0, 3))
        0:       return PRICE_MAX;
        1:       return PRICE_MIN;
        2:       return SAMPLE_W'(1);
        default: return '1;
      endcase
    end
    if (r < 55) return SAMPLE_W'($urandom_range(1000, 99999));
    return $urandom;
  endfunction

  task automatic pick_setting(output int unsigned n);
    logic [MODE_W-1:0]     m;
    logic [WLEN_W-1:0]     w;
    logic [CFG_DATA_W-1:0] mode_data;
    logic [CFG_DATA_W-1:0] wlen_data;
    logic [GAIN_BITS-1:0]  eg;
    logic [GAIN_BITS-1:0]  il;
    int                    r;
    case ($urandom_range(0, 6))
      0, 1:    m = MODE_SIMPLE;
      2, 3:    m = MODE_EXP;
      4, 5:    m = MODE_SMOOTHED;
      default: m = MODE_UNUSED;
    endcase
    r = $urandom_range(0, 19);
    if (r == 0) w = WLEN_W'($urandom_range(0, 1));
    else if (r < 8) w = WLEN_W'($urandom_range(2, 6));
    else w = WLEN_W'($urandom_range(7, 40));
    n = (w < 2) ? 2 : w;
    r = $urandom_range(0, 9);
    if (r < 6) begin
      eg = GAIN_BITS'(131072 / (n + 1));
      il = GAIN_BITS'(65536 / n);
    end else if (r < 8) begin
      eg = GAIN_BITS'($urandom_range(0, 65535));
      il = GAIN_BITS'($urandom_range(0, 65535));
    end else if (r == 8) begin
      eg = '0;
      il = '0;
    end else begin
      eg = '1;
      il = '1;
    end
    // junk in the unused upper data bits must be dropped
    mode_data = $urandom;
    mode_data[MODE_W-1:0] = m;
    wlen_data = $urandom;
    wlen_data[WLEN_W-1:0] = w;
    set_filter(mode_data, wlen_data, eg, il);
  endtask

  task automatic run_random_block(input int target);
    int                   taken;
    int                   burst;
    int unsigned          n;
    logic [SAMPLE_W-1:0]  x;
    logic [CFG_IDX_W-1:0] idx;
    taken = 0;
    // an unused register index must change nothing
    idx = CFG_IDX_W'($urandom_range(4, 15));
    write_reg(idx, CFG_DATA_W'($urandom));
    while (taken < target) begin
      pick_setting(n);
      burst = $urandom_range(n + 4, 3 * n + 20);
      repeat (burst) begin
        x = pick_price();
        send_sample(x);
        if (x != 0) taken++;
      end
      drain_results();
    end
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: simple mean over two samples, zeros pass through
    send_sample('0);
    send_sample(PRICE_MAX);
    send_sample(PRICE_MAX);
    send_sample('0);
    send_sample(PRICE_MIN);
    send_sample(PRICE_MIN);
    send_sample(SAMPLE_W'(1));
    send_sample('1);
    drain_results();

    // a gain write keeps the window; full-scale reciprocal saturates the mean
    write_reg(REG_INV_LENGTH, 16'hFFFF);
    send_sample(PRICE_MAX);
    send_sample(PRICE_MAX);
    send_sample(PRICE_MIN);
    send_sample(PRICE_MIN);
    drain_results();

    // exponential, window three with upper data bits set, maximum gain
    set_filter({14'h3FFF, MODE_EXP}, 16'hF803, 16'hFFFF, 16'd21845);
    send_sample(PRICE_MAX);
    send_sample(PRICE_MIN);
    send_sample(SAMPLE_W'(100));
    send_sample('0);
    send_sample(PRICE_MAX);
    send_sample(PRICE_MIN);
    drain_results();

    // smoothed, window below the minimum, zero gains
    set_filter({14'd0, MODE_SMOOTHED}, 16'd1, 16'd0, 16'd0);
    send_sample(SAMPLE_W'(5));
    send_sample(-SAMPLE_W'(5));
    send_sample(PRICE_MAX);
    send_sample(PRICE_MIN);
    drain_results();

    // unknown mode code behaves as simple; zero window acts as two
    set_filter({14'h3FFF, MODE_UNUSED}, 16'd0, EXP_GAIN_RST, INV_LENGTH_RST);
    send_sample(SAMPLE_W'(3));
    send_sample(-SAMPLE_W'(7));
    send_sample(SAMPLE_W'(32'h1234_5678));
    drain_results();

    snd_idle_pct = 21;
    rcv_stall_pct <= 81;
    run_random_block(60);

    snd_idle_pct = 81;
    rcv_stall_pct <= 21;
    run_random_block(60);

    snd_idle_pct = 0;
    rcv_stall_pct <= 0;
    run_random_block(60);

    // longest window: an oversized length acts as the maximum, sum at full scale
    set_filter({14'd0, MODE_EXP}, 16'h07FF, 16'd127, 16'd64);
    repeat (MAX_WINDOW_DEF) send_sample(PRICE_MAX);
    repeat (20) send_sample(pick_price());
    drain_results();
    repeat (FINAL_SETTLE) @(posedge clk);

    if (fail_count == 0 && pending == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/maf_pkg.sv
rtl/maf_ram.sv
rtl/maf_front.sv
rtl/maf_accum.sv
rtl/maf_smooth.sv
rtl/moving_average_filter.sv
tb/sv/moving_average_checker.sv
tb/sv/moving_average_filter_tb.sv
